// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignored while reset is high
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/srtc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package srtc_pkg;

   // Geometry used after reset and in place of a zero register
   localparam logic [5:0] DEFAULT_GEOMETRY = 6'd9;
   // Longest run taken from one request
   localparam int MAX_COUNT = 64;
   // Checksummed sectors at the start of track 0 side 0
   localparam int CHECKSUM_SECTORS = 6;
   // Quotient bits produced by the divider, one per cycle
   localparam int DIV_BITS = 16;

   // Configuration register indexes
   localparam logic CSR_SECTORS_PER_TRACK    = 1'b0;
   localparam logic CSR_SECTORS_PER_CYLINDER = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic div_step;
      logic emit;
   } ctl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic total_zero;
      logic div_last;
      logic out_free;
      logic emit_last;
      logic emit_redivide;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== src/srtc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module srtc_ctrl import srtc_pkg::*; (
   input  wire           clock,
   input  wire           reset,
   input  wire           req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output ctl_cmd_type   cmd
);

   state_type state_ff, state_in;

   // Hold the controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequence: take a request, divide, emit chunks, divide again past the next track or on a record wrap
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            // keep the input closed while reset is high
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.load = 1'b1;
               if (!status.total_zero) begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.emit_last) begin
                  state_in = ST_IDLE;
               end else if (status.emit_redivide) begin
                  state_in = ST_DIV;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== src/srtc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module srtc_datapath import srtc_pkg::*; #(
   parameter int RUN_LIMIT      = MAX_COUNT,
   parameter int CHECKSUM_COUNT = CHECKSUM_SECTORS
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                csr_wr_en,
   input  wire                csr_index,
   input  wire  [6:0]         csr_wdata,
   input  wire  [15:0]        start_record,
   input  wire  [6:0]         sector_total,
   input  wire                is_write,
   input  wire                buffer_unaligned,
   input  ctl_cmd_type        cmd,
   output dp_status_type      status,
   input  wire                rsp_tready,
   output logic               rsp_tvalid,
   output logic [15:0]        track_number,
   output logic               side_number,
   output logic [5:0]         first_sector,
   output logic [5:0]         chunk_length,
   output logic               refresh_checksums,
   output logic               last_chunk
);

   localparam int CNT_W = $clog2(DIV_BITS);

   // Configuration registers
   logic [5:0] spt_cfg_ff;
   logic [6:0] spc_cfg_ff;

   // Request registers
   logic [15:0] rec_ff, rec_in;
   logic [6:0]  left_ff, left_in;
   logic        wr_ff, odd_ff;
   logic [5:0]  spt_ff, spt_in;
   logic [6:0]  spc_ff, spc_in;

   // Divider / position registers: quotient doubles as track, remainder as sector
   logic [15:0]      quo_ff, quo_in;
   logic [6:0]       rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Output register
   logic        valid_ff, valid_in;
   logic [15:0] o_track_ff;
   logic        o_side_ff, o_refresh_ff, o_last_ff;
   logic [5:0]  o_first_ff, o_len_ff;

   logic [6:0]  spt2;
   logic [7:0]  partial, part_diff;
   logic        part_ge;
   logic        side;
   logic [5:0]  sect, room, len;
   logic [6:0]  left_next;
   logic [16:0] rec_sum;
   logic [7:0]  sect_sum;
   logic        refresh;
   logic        redivide;

   // Write the geometry registers
   always_ff @(posedge clock) begin
      if (reset) begin
         spt_cfg_ff <= DEFAULT_GEOMETRY;
         spc_cfg_ff <= {1'b0, DEFAULT_GEOMETRY};
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SECTORS_PER_TRACK:    spt_cfg_ff <= csr_wdata[5:0];
            CSR_SECTORS_PER_CYLINDER: spc_cfg_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Settle the geometry actually used: defaults for zero, at most two sides
   always_comb begin
      spt_in = spt_cfg_ff;
      spc_in = spc_cfg_ff;
      if (spc_cfg_ff == 7'd0) begin
         spt_in = DEFAULT_GEOMETRY;
         spc_in = {1'b0, DEFAULT_GEOMETRY};
      end
      if (spt_in == 6'd0) begin
         spt_in = DEFAULT_GEOMETRY;
      end
      spt2 = {spt_in, 1'b0};
      if (spc_in > spt2) begin
         spc_in = spt2;
      end
   end

   // One restoring division step
   always_comb begin
      partial   = {rem_ff, quo_ff[DIV_BITS-1]};
      part_ge   = partial >= {1'b0, spc_ff};
      part_diff = partial - {1'b0, spc_ff};
   end

   // Current chunk from the position registers
   always_comb begin
      side = {1'b0, spt_ff} <= rem_ff;
      sect = side ? 6'(rem_ff - {1'b0, spt_ff}) : rem_ff[5:0];
      room = spt_ff - sect;
      if (odd_ff) begin
         len = 6'd1;
      end else if ({1'b0, room} < left_ff) begin
         len = room;
      end else begin
         len = left_ff[5:0];
      end
      left_next = left_ff - {1'b0, len};
      refresh   = wr_ff && (quo_ff == 16'd0) && !side && (sect < 6'(CHECKSUM_COUNT));
      rec_sum   = {1'b0, rec_ff} + {11'd0, len};
      sect_sum  = {1'b0, rem_ff} + {2'd0, len};
      redivide  = rec_sum[16] || (sect_sum >= {spc_ff, 1'b0});
   end

   // Next values of the request and position registers
   always_comb begin
      rec_in  = rec_ff;
      left_in = left_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (cmd.load) begin
         rec_in  = start_record;
         left_in = (32'(sector_total) > RUN_LIMIT) ? 7'(RUN_LIMIT) : sector_total;
         quo_in  = start_record;
         rem_in  = '0;
         cnt_in  = '0;
      end else if (cmd.div_step) begin
         quo_in = {quo_ff[DIV_BITS-2:0], part_ge};
         rem_in = part_ge ? part_diff[6:0] : partial[6:0];
         cnt_in = cnt_ff + 1'b1;
      end else if (cmd.emit) begin
         rec_in  = rec_sum[15:0];
         left_in = left_next;
         if (redivide) begin
            // Restart the division on the new record
            quo_in = rec_sum[15:0];
            rem_in = '0;
            cnt_in = '0;
         end else if (sect_sum >= {1'b0, spc_ff}) begin
            quo_in = quo_ff + 16'd1;
            rem_in = 7'(sect_sum - {1'b0, spc_ff});
         end else begin
            rem_in = sect_sum[6:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rec_ff  <= rec_in;
      left_ff <= left_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      if (cmd.load) begin
         wr_ff  <= is_write;
         odd_ff <= buffer_unaligned;
         spt_ff <= spt_in;
         spc_ff <= spc_in;
      end
   end

   // Output word: load on emit, drop once taken
   always_comb begin
      valid_in = valid_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         o_track_ff   <= quo_ff;
         o_side_ff    <= side;
         o_first_ff   <= sect + 6'd1;
         o_len_ff     <= len;
         o_refresh_ff <= refresh;
         o_last_ff    <= left_next == 7'd0;
      end
   end

   assign status.total_zero    = sector_total == 7'd0;
   assign status.div_last      = cnt_ff == CNT_W'(DIV_BITS - 1);
   assign status.out_free      = !valid_ff || rsp_tready;
   assign status.emit_last     = left_next == 7'd0;
   assign status.emit_redivide = redivide;

   assign rsp_tvalid        = valid_ff;
   assign track_number      = o_track_ff;
   assign side_number       = o_side_ff;
   assign first_sector      = o_first_ff;
   assign chunk_length      = o_len_ff;
   assign refresh_checksums = o_refresh_ff;
   assign last_chunk        = o_last_ff;

endmodule
`default_nettype wire

// ===== src/sector_run_to_track_chunks_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | tdata (low bit up)                          | tuser / tlast
// req_    | in  | start_record[15:0], sector_total[22:16]     | is_write, buffer_unaligned
// rsp_    | out | track, side, first_sector, chunk_length     | refresh_checksums / last_chunk
// csr_    | in  | index 0 sectors_per_track, 1 sectors_per_cylinder
//
// A request first goes through a bit-serial division of the record by the cylinder
// size, then yields one chunk per cycle while rsp_tready holds. A chunk crossing
// more than one cylinder, or the record wrapping past 65535, costs another
// division. A zero count is taken without a division.
// Reset is synchronous and holds req_tready low; geometry returns to 9 and 9.
// A stalled output word holds until taken; req_tready is low until the last chunk.
module sector_run_to_track_chunks_unit import srtc_pkg::*; #(
   parameter int RUN_LIMIT      = MAX_COUNT,
   parameter int CHECKSUM_COUNT = CHECKSUM_SECTORS
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,   // start_record[15:0], sector_total[22:16], zero
   input  wire  [1:0]  req_tuser,   // is_write[0], buffer_unaligned[1]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // track_number[15:0], side_number[16],
                                    // first_sector[22:17], chunk_length[28:23], zero
   output logic        rsp_tuser,   // refresh_checksums
   output logic        rsp_tlast,   // last_chunk
   input  wire         csr_wr_en,
   input  wire         csr_index,
   input  wire  [6:0]  csr_wdata
);

   ctl_cmd_type   cmd;
   dp_status_type status;
   logic [15:0]   track_number;
   logic          side_number;
   logic [5:0]    first_sector;
   logic [5:0]    chunk_length;

   srtc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   srtc_datapath #(
      .RUN_LIMIT      (RUN_LIMIT),
      .CHECKSUM_COUNT (CHECKSUM_COUNT)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .start_record      (req_tdata[15:0]),
      .sector_total      (req_tdata[22:16]),
      .is_write          (req_tuser[0]),
      .buffer_unaligned  (req_tuser[1]),
      .cmd               (cmd),
      .status            (status),
      .rsp_tready        (rsp_tready),
      .rsp_tvalid        (rsp_tvalid),
      .track_number      (track_number),
      .side_number       (side_number),
      .first_sector      (first_sector),
      .chunk_length      (chunk_length),
      .refresh_checksums (rsp_tuser),
      .last_chunk        (rsp_tlast)
   );

   // Pack the output word
   assign rsp_tdata = {3'd0, chunk_length, first_sector, side_number, track_number};

endmodule
`default_nettype wire

// ===== src/srtc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module srtc_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire [23:0] req_tdata,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [31:0] rsp_tdata,
   input wire        rsp_tuser,
   input wire        rsp_tlast
);

   // A stalled word holds
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled chunk changed")

   // No new request while a run is still being split
   `ASSERT_CLK_RST(a_busy, clock, reset, rsp_tvalid && !rsp_tlast |-> !req_tready, "request taken mid-run")

   // Every chunk moves at least one sector from a 1-based sector
   `ASSERT_CLK_RST(a_len, clock, reset, rsp_tvalid |-> (rsp_tdata[28:23] != 6'd0) && (rsp_tdata[22:17] != 6'd0), "empty chunk or zero sector")

   // Checksum refresh only on track 0 side 0
   `ASSERT_CLK_RST(a_refresh, clock, reset, rsp_tvalid && rsp_tuser |-> rsp_tdata[16:0] == 17'd0, "refresh off track 0 side 0")

   // A zero-count request leaves the input open
   `ASSERT_CLK_RST(a_zero, clock, reset, req_tvalid && req_tready && (req_tdata[22:16] == 7'd0) |=> req_tready, "zero count blocked input")

endmodule

bind sector_run_to_track_chunks_unit srtc_checker u_srtc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
